FILE: src/vsac_pkg.sv
// Shared types and constants for the vital-sign alarm classifier.
// No dependencies; imported by every module of the block.
package vsac_pkg;

  typedef enum logic [1:0] {
    LvlNormal  = 2'd0,
    LvlWarning = 2'd1,
    LvlAlarm   = 2'd2,
    LvlNoData  = 2'd3
  } lvl_e;

  localparam int unsigned NumLanes = 8;
  localparam int unsigned GradeW   = 19;  // signed width common to all lanes

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CfgTempLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTempHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHumLow   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHumHigh  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPresLow  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPresHigh = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgAlarmEn  = 3'd6;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 8;

  // lane order of the presence mask
  localparam int unsigned LaneTemp  = 0;
  localparam int unsigned LaneHum   = 1;
  localparam int unsigned LanePres  = 2;
  localparam int unsigned LaneSpo2  = 3;
  localparam int unsigned LanePulse = 4;
  localparam int unsigned LaneEcg   = 5;
  localparam int unsigned LaneResp  = 6;
  localparam int unsigned LaneGlu   = 7;

  // fixed vital-sign ranges, hundredths
  localparam logic signed [GradeW-1:0] Spo2Lo  = GradeW'(9500);
  localparam logic signed [GradeW-1:0] Spo2Hi  = GradeW'(10000);
  localparam logic signed [GradeW-1:0] HrLo    = GradeW'(6000);
  localparam logic signed [GradeW-1:0] HrHi    = GradeW'(10000);
  localparam logic signed [GradeW-1:0] RespLo  = GradeW'(1200);
  localparam logic signed [GradeW-1:0] RespHi  = GradeW'(2500);
  localparam logic signed [GradeW-1:0] GluLo   = GradeW'(390);
  localparam logic signed [GradeW-1:0] GluHi   = GradeW'(610);

  localparam logic [14:0] EcgBaseMin = 15'd100;

  typedef struct packed {
    logic [14:0] temp_low;
    logic [14:0] temp_high;
    logic [13:0] hum_low;
    logic [13:0] hum_high;
    logic [16:0] pres_low;
    logic [16:0] pres_high;
    logic        alarm_enable;
  } cfg_t;

  typedef struct packed {
    logic        upd;
    logic [14:0] rate;
  } ecg_req_t;

endpackage

FILE: src/vsac_cfg_regs.sv
// Configuration register file of the alarm classifier.
// Depends on vsac_pkg.
module vsac_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vsac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vsac_pkg::CfgDataW-1:0] cfg_data_i,
  output vsac_pkg::cfg_t                cfg_o
);
  import vsac_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTempLow:  cfg_d.temp_low     = cfg_data_i[14:0];
        CfgTempHigh: cfg_d.temp_high    = cfg_data_i[14:0];
        CfgHumLow:   cfg_d.hum_low      = cfg_data_i[13:0];
        CfgHumHigh:  cfg_d.hum_high     = cfg_data_i[13:0];
        CfgPresLow:  cfg_d.pres_low     = cfg_data_i[16:0];
        CfgPresHigh: cfg_d.pres_high    = cfg_data_i[16:0];
        CfgAlarmEn:  cfg_d.alarm_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_low     <= 15'd1800;
      cfg_q.temp_high    <= 15'd2800;
      cfg_q.hum_low      <= 14'd3000;
      cfg_q.hum_high     <= 14'd7000;
      cfg_q.pres_low     <= 17'd95000;
      cfg_q.pres_high    <= 17'd105000;
      cfg_q.alarm_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/vsac_lane_grade.sv
// Range grader for one reading: alarm outside [lo, hi], warning within a
// tenth of the span from either edge. Depends on vsac_pkg.
module vsac_lane_grade (
  input  logic signed [vsac_pkg::GradeW-1:0] val_i,
  input  logic signed [vsac_pkg::GradeW-1:0] lo_i,
  input  logic signed [vsac_pkg::GradeW-1:0] hi_i,
  output vsac_pkg::lvl_e                     lvl_o
);
  import vsac_pkg::*;

  logic signed [GradeW:0]   off_lo, off_hi, span;
  logic signed [GradeW+4:0] off_lo_x, off_hi_x, span_x;

  assign off_lo = {val_i[GradeW-1], val_i} - {lo_i[GradeW-1], lo_i};
  assign off_hi = {hi_i[GradeW-1], hi_i} - {val_i[GradeW-1], val_i};
  assign span   = {hi_i[GradeW-1], hi_i} - {lo_i[GradeW-1], lo_i};

  // x10 as x8 + x2
  assign off_lo_x = ({{4{off_lo[GradeW]}}, off_lo} <<< 3)
                  + ({{4{off_lo[GradeW]}}, off_lo} <<< 1);
  assign off_hi_x = ({{4{off_hi[GradeW]}}, off_hi} <<< 3)
                  + ({{4{off_hi[GradeW]}}, off_hi} <<< 1);
  assign span_x   = {{4{span[GradeW]}}, span};

  always_comb begin
    if (val_i < lo_i || val_i > hi_i) begin
      lvl_o = LvlAlarm;
    end else if (off_lo_x < span_x || off_hi_x < span_x) begin
      lvl_o = LvlWarning;
    end else begin
      lvl_o = LvlNormal;
    end
  end

endmodule

FILE: src/vsac_ecg_track.sv
// Last ECG rate store and jump detector (jump above 30% of max(prev, 1.00)).
// Depends on vsac_pkg.
module vsac_ecg_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [14:0]       cur_i,
  input  vsac_pkg::ecg_req_t req_i,
  output logic              jump_o
);
  import vsac_pkg::*;

  logic [14:0] rate_q, rate_d;
  logic        known_q, known_d;
  logic [14:0] diff, base;
  logic [18:0] diff_x10;
  logic [16:0] base_x3;

  assign diff     = (cur_i >= rate_q) ? (cur_i - rate_q) : (rate_q - cur_i);
  assign base     = (rate_q > EcgBaseMin) ? rate_q : EcgBaseMin;
  assign diff_x10 = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
  assign base_x3  = {1'b0, base, 1'b0} + {2'b00, base};
  assign jump_o   = known_q && (diff_x10 > {2'b00, base_x3});

  assign rate_d  = req_i.upd ? req_i.rate : rate_q;
  assign known_d = known_q | req_i.upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= '0;
      known_q <= 1'b0;
    end else begin
      rate_q  <= rate_d;
      known_q <= known_d;
    end
  end

endmodule

FILE: src/vital_sign_alarm_classifier_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   128+1  one sample set: readings and presence mask, valid flag
// m_axis    out  8      alarm level
// cfg       in   3+17   register write, index and data
//
// One request per cycle sustained unless m_axis stalls. A set passes the input
// register, one grading pass, then the result register. The ECG rate store is
// updated as an enabled, valid set with ECG present enters the result register.
// A stalled result holds; the input register still takes one more set.
// Reset: registers to their defaults, no stored ECG rate, both stages empty.
// Depends on vsac_pkg, vsac_cfg_regs, vsac_lane_grade, vsac_ecg_track.
module vital_sign_alarm_classifier_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] present_mask, [22:8] temperature, [36:23] humidity,
  // [53:37] pressure, [67:54] oxygen_sat, [82:68] pulse_rate,
  // [97:83] ecg_rate, [111:98] resp_rate, [124:112] glucose_level
  input  logic [vsac_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] set_valid
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] alarm_level
  output logic [vsac_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [vsac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vsac_pkg::CfgDataW-1:0] cfg_data_i
);
  import vsac_pkg::*;

  cfg_t     cfg;
  ecg_req_t ecg_req;
  logic     ecg_jump;

  logic               in_valid_q, in_valid_d;
  logic [InDataW-1:0] in_data_q;
  logic               in_user_q;
  logic               out_valid_q, out_valid_d;
  lvl_e               out_lvl_q, out_lvl_d;
  logic               take_in, advance;

  logic [7:0]  mask;
  logic [14:0] ecg_rate;
  logic signed [GradeW-1:0] lane_v  [NumLanes];
  logic signed [GradeW-1:0] lane_lo [NumLanes];
  logic signed [GradeW-1:0] lane_hi [NumLanes];
  lvl_e                     lane_lvl[NumLanes];
  lvl_e                     worst;

  vsac_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake and stage control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
    if (advance) begin
      out_lvl_q <= out_lvl_d;
    end
  end

  // field unpacking
  assign mask     = in_data_q[7:0];
  assign ecg_rate = in_data_q[97:83];

  assign lane_v[LaneTemp]  = $signed({{(GradeW-15){in_data_q[22]}}, in_data_q[22:8]});
  assign lane_v[LaneHum]   = $signed(GradeW'(in_data_q[36:23]));
  assign lane_v[LanePres]  = $signed(GradeW'(in_data_q[53:37]));
  assign lane_v[LaneSpo2]  = $signed(GradeW'(in_data_q[67:54]));
  assign lane_v[LanePulse] = $signed(GradeW'(in_data_q[82:68]));
  assign lane_v[LaneEcg]   = $signed(GradeW'(ecg_rate));
  assign lane_v[LaneResp]  = $signed(GradeW'(in_data_q[111:98]));
  assign lane_v[LaneGlu]   = $signed(GradeW'(in_data_q[124:112]));

  assign lane_lo[LaneTemp]  = $signed({{(GradeW-15){cfg.temp_low[14]}}, cfg.temp_low});
  assign lane_hi[LaneTemp]  = $signed({{(GradeW-15){cfg.temp_high[14]}}, cfg.temp_high});
  assign lane_lo[LaneHum]   = $signed(GradeW'(cfg.hum_low));
  assign lane_hi[LaneHum]   = $signed(GradeW'(cfg.hum_high));
  assign lane_lo[LanePres]  = $signed(GradeW'(cfg.pres_low));
  assign lane_hi[LanePres]  = $signed(GradeW'(cfg.pres_high));
  assign lane_lo[LaneSpo2]  = Spo2Lo;
  assign lane_hi[LaneSpo2]  = Spo2Hi;
  assign lane_lo[LanePulse] = HrLo;
  assign lane_hi[LanePulse] = HrHi;
  assign lane_lo[LaneEcg]   = HrLo;
  assign lane_hi[LaneEcg]   = HrHi;
  assign lane_lo[LaneResp]  = RespLo;
  assign lane_hi[LaneResp]  = RespHi;
  assign lane_lo[LaneGlu]   = GluLo;
  assign lane_hi[LaneGlu]   = GluHi;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    vsac_lane_grade u_grade (
      .val_i (lane_v[g]),
      .lo_i  (lane_lo[g]),
      .hi_i  (lane_hi[g]),
      .lvl_o (lane_lvl[g])
    );
  end

  assign ecg_req.upd  = advance && in_user_q && cfg.alarm_enable && mask[LaneEcg];
  assign ecg_req.rate = ecg_rate;

  vsac_ecg_track u_ecg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cur_i  (ecg_rate),
    .req_i  (ecg_req),
    .jump_o (ecg_jump)
  );

  always_comb begin
    worst = LvlNormal;
    for (int i = 0; i < NumLanes; i++) begin
      if (mask[i] && (lane_lvl[i] > worst)) begin
        worst = lane_lvl[i];
      end
    end
    if (mask[LaneEcg] && ecg_jump) begin
      worst = LvlAlarm;
    end
  end

  always_comb begin
    if (!in_user_q) begin
      out_lvl_d = LvlNoData;
    end else if (!cfg.alarm_enable) begin
      out_lvl_d = LvlNormal;
    end else begin
      out_lvl_d = worst;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, out_lvl_q};

`ifndef ASSERT_OFF
  a_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_user_q |=> m_axis_tvalid && m_axis_tdata[1:0] == LvlNoData)
    else $error("invalid set did not give no-data");

  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_user_q && !cfg.alarm_enable |=> m_axis_tdata[1:0] == LvlNormal)
    else $error("disabled alarm did not give normal");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled while a stage was free");

  a_ecg_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecg_req.upd |-> advance && in_user_q && mask[LaneEcg])
    else $error("ECG store updated without a graded set");
`endif

endmodule
